// ----- design/efcd_pkg.sv -----
// Shared types, constants and the byte-wide CRC-32 step of the frame deframer.
`default_nettype none
package efcd_pkg;

  localparam int EFCD_LEN_COUNT_WIDTH = 16;
  localparam int EFCD_QUEUE_DEPTH     = 2;
  localparam int CFG_INDEX_WIDTH      = 3;
  localparam int CFG_DATA_WIDTH       = 16;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_BODY_LENGTH  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MATCH_START_CODE = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIXEL_CODE       = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ELIMINATED_CODE  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MATCH_END_CODE   = 3'd4;

  // Summary status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ERROR     = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN   = 2'd2;
  localparam logic [1:0] STATUS_MATCH_END = 2'd3;

  // Item kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Type codes used by the back end to classify a summary.
  typedef struct packed {
    logic [7:0] match_start;
    logic [7:0] pixel;
    logic [7:0] eliminated;
    logic [7:0] match_end;
  } codes_t;

  // One queued request from the front end to the back end.
  typedef struct packed {
    logic        kind;
    logic        fail;
    logic [7:0]  data;
    logic [31:0] number;
    logic [7:0]  etype;
    logic [15:0] plen;
  } entry_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- design/efcd_if.sv -----
// Handshake channel interfaces of the frame deframer: input bytes, results, configuration.
`default_nettype none
interface efcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_start;
  logic       buffer_end;
  modport source (output valid, in_byte, frame_start, buffer_end, input ready);
  modport sink (input valid, in_byte, frame_start, buffer_end, output ready);
endinterface

interface efcd_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [31:0] event_number;
  logic [7:0]  evt_type;
  logic [15:0] payload_length;
  logic [1:0]  status;
  modport source (output valid, out_kind, out_byte, event_number, evt_type,
                  payload_length, status, input ready);
  modport sink (input valid, out_kind, out_byte, event_number, evt_type,
                payload_length, status, output ready);
endinterface

interface efcd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [efcd_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [efcd_pkg::CFG_DATA_WIDTH-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/event_frame_crc_deframer.sv -----
// Top level of the length-prefixed frame deframer with CRC-32 check.
// Path: a byte's result (payload byte or frame summary) is put into the queue at the
//   edge that accepts the byte, then loaded into the back end's output register.
// Throughput: one byte per cycle, set by the byte-wide CRC-32 update in the parser; the
//   input stalls only while the two-entry queue is full behind a stalled sink.
// Reset (synchronous, rst_n low): parser idle, queue and output register empty,
//   configuration registers at their defaults (limit 65535, codes 0, 1, 2 and 3).
`default_nettype none
module event_frame_crc_deframer #(
  parameter int LEN_COUNT_WIDTH = efcd_pkg::EFCD_LEN_COUNT_WIDTH,
  parameter int QUEUE_DEPTH     = efcd_pkg::EFCD_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  efcd_in_if.sink    in_ch,
  efcd_out_if.source out_ch,
  efcd_cfg_if.sink   cfg_ch
);
  import efcd_pkg::*;

  // Configuration registers. Writes must arrive only while the block is idle; the
  // block does not enforce it. The port is always ready; writes land at the next edge.
  logic [15:0] max_body_length_r;
  logic [7:0]  match_start_code_r;
  logic [7:0]  pixel_code_r;
  logic [7:0]  eliminated_code_r;
  logic [7:0]  match_end_code_r;
  logic        cfg_write;

  codes_t      codes;
  entry_t      push_entry;
  entry_t      head;
  logic        q_push, q_pop, q_not_full, q_not_empty;

  assign cfg_ch.ready = 1'b1;
  assign cfg_write    = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_length_r  <= 16'hFFFF;
      match_start_code_r <= 8'd0;
      pixel_code_r       <= 8'd1;
      eliminated_code_r  <= 8'd2;
      match_end_code_r   <= 8'd3;
    end else if (cfg_write) begin
      case (cfg_ch.index)
        REG_MAX_BODY_LENGTH:  max_body_length_r  <= cfg_ch.data;
        REG_MATCH_START_CODE: match_start_code_r <= cfg_ch.data[7:0];
        REG_PIXEL_CODE:       pixel_code_r       <= cfg_ch.data[7:0];
        REG_ELIMINATED_CODE:  eliminated_code_r  <= cfg_ch.data[7:0];
        REG_MATCH_END_CODE:   match_end_code_r   <= cfg_ch.data[7:0];
        default: begin
          // Indexes past the register list are dropped.
        end
      endcase
    end
  end

  // Packed in field order: start, pixel, eliminated, end.
  assign codes = {match_start_code_r, pixel_code_r, eliminated_code_r, match_end_code_r};

  // The front end parses each byte as it is accepted, runs the CRC over the
  // length field and body, and posts a request for every payload byte and
  // for every summary (good or failed). Its ready follows queue space only.
  efcd_front #(
    .LEN_COUNT_WIDTH(LEN_COUNT_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .max_body_length (max_body_length_r),
    .q_ready         (q_not_full),
    .q_push          (q_push),
    .q_entry         (push_entry)
  );

  // The queue lets the parser keep taking bytes while a result waits for
  // the sink, and lets the output side drain while the source idles.
  efcd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  // The back end resolves the summary status from the type codes and holds
  // the result in its output register until the sink takes it.
  efcd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .codes   (codes),
    .q_valid (q_not_empty),
    .q_head  (head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ----- design/efcd_front.sv -----
// Front end: frame parser, length check and CRC-32, one byte per cycle while the queue has space.
`default_nettype none
module efcd_front #(
  parameter int LEN_COUNT_WIDTH = efcd_pkg::EFCD_LEN_COUNT_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  efcd_in_if.sink                     in_ch,
  input  wire logic [15:0]            max_body_length,
  input  wire logic                   q_ready,
  output logic                        q_push,
  output efcd_pkg::entry_t            q_entry
);
  import efcd_pkg::*;

  localparam int W = LEN_COUNT_WIDTH;

  typedef enum logic [2:0] {PH_IDLE, PH_LEN, PH_NUM, PH_TYPE, PH_PAY, PH_CRC} phase_t;

  phase_t         phase_r, phase_nxt, cur_phase;
  logic [W-1:0]   body_length_r, body_length_nxt, cur_len;
  logic [W-1:0]   byte_count_r, byte_count_nxt, cur_cnt, cnt_inc;
  logic [31:0]    crc_r, crc_nxt, cur_crc;
  logic [31:0]    crc_rx_r, crc_rx_nxt, cur_rx;
  logic [31:0]    number_r, number_nxt, cur_num;
  logic [7:0]     type_r, type_nxt, cur_type;
  logic           length_bad_r, length_bad_nxt, cur_bad;
  logic           accept, push, fail, done;
  logic [31:0]    plen_wide;
  entry_t         entry;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept && push;
  assign q_entry     = entry;

  always_comb begin
    if (in_ch.frame_start) begin
      cur_phase = PH_LEN;
      cur_len   = '0;
      cur_cnt   = '0;
      cur_crc   = CRC_INIT;
      cur_rx    = '0;
      cur_num   = '0;
      cur_type  = '0;
      cur_bad   = 1'b0;
    end else begin
      cur_phase = phase_r;
      cur_len   = body_length_r;
      cur_cnt   = byte_count_r;
      cur_crc   = crc_r;
      cur_rx    = crc_rx_r;
      cur_num   = number_r;
      cur_type  = type_r;
      cur_bad   = length_bad_r;
    end

    phase_nxt       = cur_phase;
    body_length_nxt = cur_len;
    byte_count_nxt  = cur_cnt;
    crc_nxt         = cur_crc;
    crc_rx_nxt      = cur_rx;
    number_nxt      = cur_num;
    type_nxt        = cur_type;
    length_bad_nxt  = cur_bad;
    cnt_inc         = cur_cnt + W'(1);
    plen_wide       = 32'(cur_len) - 32'd5;
    push            = 1'b0;
    fail            = 1'b0;
    done            = 1'b0;
    entry           = '0;

    case (cur_phase)
      PH_IDLE: begin
        done = 1'b1;
      end
      PH_LEN: begin
        crc_nxt         = crc_byte(cur_crc, in_ch.in_byte);
        length_bad_nxt  = cur_bad || (cur_len[W-1:W-8] != 8'd0);
        body_length_nxt = W'({cur_len, in_ch.in_byte});
        byte_count_nxt  = cnt_inc;
        if (cnt_inc == W'(4)) begin
          if (length_bad_nxt || (body_length_nxt < W'(5)) ||
              (33'(body_length_nxt) > 33'(max_body_length))) begin
            fail = 1'b1;
            done = 1'b1;
          end else begin
            phase_nxt      = PH_NUM;
            byte_count_nxt = '0;
          end
        end
      end
      PH_NUM: begin
        crc_nxt        = crc_byte(cur_crc, in_ch.in_byte);
        number_nxt     = {cur_num[23:0], in_ch.in_byte};
        byte_count_nxt = cnt_inc;
        if (cnt_inc == W'(4)) begin
          phase_nxt      = PH_TYPE;
          byte_count_nxt = '0;
        end
      end
      PH_TYPE: begin
        crc_nxt        = crc_byte(cur_crc, in_ch.in_byte);
        type_nxt       = in_ch.in_byte;
        phase_nxt      = (cur_len == W'(5)) ? PH_CRC : PH_PAY;
        byte_count_nxt = '0;
      end
      PH_PAY: begin
        crc_nxt        = crc_byte(cur_crc, in_ch.in_byte);
        push           = 1'b1;
        entry.kind     = KIND_PAYLOAD;
        entry.data     = in_ch.in_byte;
        byte_count_nxt = cnt_inc;
        if (cnt_inc >= (cur_len - W'(5))) begin
          phase_nxt      = PH_CRC;
          byte_count_nxt = '0;
        end
      end
      PH_CRC: begin
        crc_rx_nxt     = {cur_rx[23:0], in_ch.in_byte};
        byte_count_nxt = cnt_inc;
        if (cnt_inc == W'(4)) begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
          if (~cur_crc != crc_rx_nxt) begin
            fail = 1'b1;
          end else begin
            push         = 1'b1;
            entry.kind   = KIND_SUMMARY;
            entry.number = cur_num;
            entry.etype  = cur_type;
            entry.plen   = plen_wide[15:0];
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        done      = 1'b1;
      end
    endcase

    // A buffer that ends before the frame does replaces this byte's result.
    if (!done && in_ch.buffer_end) begin
      fail = 1'b1;
    end
    if (fail) begin
      phase_nxt  = PH_IDLE;
      push       = 1'b1;
      entry      = '0;
      entry.kind = KIND_SUMMARY;
      entry.fail = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      body_length_r <= '0;
      byte_count_r  <= '0;
      crc_r         <= CRC_INIT;
      crc_rx_r      <= '0;
      number_r      <= '0;
      type_r        <= '0;
      length_bad_r  <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      body_length_r <= body_length_nxt;
      byte_count_r  <= byte_count_nxt;
      crc_r         <= crc_nxt;
      crc_rx_r      <= crc_rx_nxt;
      number_r      <= number_nxt;
      type_r        <= type_nxt;
      length_bad_r  <= length_bad_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/efcd_queue.sv -----
// Short request queue between the front end and the back end.
`default_nettype none
module efcd_queue #(
  parameter int DEPTH = efcd_pkg::EFCD_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire efcd_pkg::entry_t push_entry,
  output logic                  not_full,
  input  wire logic             pop,
  output logic                  not_empty,
  output efcd_pkg::entry_t      head
);
  import efcd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign not_full  = (count_r != CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ----- design/efcd_back.sv -----
// Back end: classifies summaries by type code and holds the result register.
`default_nettype none
module efcd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire efcd_pkg::codes_t codes,
  input  wire logic             q_valid,
  input  wire efcd_pkg::entry_t q_head,
  output logic                  q_pop,
  efcd_out_if.source            out_ch
);
  import efcd_pkg::*;

  logic        out_valid_r;
  logic        kind_r;
  logic [7:0]  byte_r;
  logic [31:0] number_r;
  logic [7:0]  type_r;
  logic [15:0] plen_r;
  logic [1:0]  status_r, status_nxt;
  logic        load;

  assign load  = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop = load;

  always_comb begin
    if (q_head.fail) begin
      status_nxt = STATUS_ERROR;
    end else if (q_head.kind == KIND_PAYLOAD) begin
      status_nxt = STATUS_OK;
    end else if (q_head.etype == codes.match_start || q_head.etype == codes.pixel ||
                 q_head.etype == codes.eliminated) begin
      status_nxt = STATUS_OK;
    end else if (q_head.etype == codes.match_end) begin
      status_nxt = STATUS_MATCH_END;
    end else begin
      status_nxt = STATUS_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= q_head.kind;
      byte_r   <= q_head.data;
      number_r <= q_head.number;
      type_r   <= q_head.etype;
      plen_r   <= q_head.plen;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_kind       = kind_r;
  assign out_ch.out_byte       = byte_r;
  assign out_ch.event_number   = number_r;
  assign out_ch.evt_type       = type_r;
  assign out_ch.payload_length = plen_r;
  assign out_ch.status         = status_r;

endmodule
`default_nettype wire
